// ===== design/fvn_pkg.sv =====
// Shared constants, types and helper functions for the 2D fractal value noise block.
// No dependencies; every other file of the block imports this package.
package fvn_pkg;

    localparam int MAX_OCTAVES = 16;
    localparam int OCT_W       = 5;
    localparam int VAL_W       = 24;
    localparam logic [23:0] VAL_MAX = 24'hffffff;
    localparam logic [31:0] FBM_SEED_STEP   = 32'd7919;
    localparam logic [31:0] RIDGE_SEED_STEP = 32'd6151;

    localparam logic [2:0] REG_SEED = 3'd0;
    localparam logic [2:0] REG_OCT  = 3'd1;
    localparam logic [2:0] REG_LAC  = 3'd2;
    localparam logic [2:0] REG_GAIN = 3'd3;
    localparam logic [2:0] REG_MODE = 3'd4;

    // Configuration snapshot that rides with each request.
    typedef struct packed {
        logic [31:0] seed;
        logic [4:0]  octaves;
        logic [15:0] lacunarity;
        logic [15:0] gain;
        logic        mode;
    } t_cfg;

    // Running accumulation handed from cell to cell.
    typedef struct packed {
        logic [31:0] xc;
        logic [31:0] zc;
        logic [31:0] freq;
        logic [32:0] amp;
        logic [63:0] sum;
        logic [37:0] norm;
        t_cfg        cfg;
    } t_acc;

    // Lattice hash input word for one corner.
    function automatic logic [31:0] hash_in(input logic [31:0] s, input logic [31:0] ix,
                                            input logic [31:0] iz);
        begin
            return (ix * 32'h9e3779b1) ^ (iz * 32'h85ebca6b) ^ (s * 32'hc2b2ae35);
        end
    endfunction

    // First half of one mix round: fold and first multiply.
    function automatic logic [31:0] mix_step1(input logic [31:0] v_in);
        logic [31:0] v;
        begin
            v = v_in ^ (v_in >> 16);
            return v * 32'h7feb352d;
        end
    endfunction

    // Second half of one mix round: fold, second multiply, final fold.
    function automatic logic [31:0] mix_step2(input logic [31:0] v_in);
        logic [31:0] v;
        begin
            v = v_in ^ (v_in >> 15);
            v = v * 32'h846ca68b;
            return v ^ (v >> 16);
        end
    endfunction

endpackage

// ===== design/fvn_cell.sv =====
// One octave cell of the fractal noise chain: registered pipeline for a single octave.
// Depends on fvn_pkg; instantiated MAX_OCTAVES times by fractal_value_noise_2d.
module fvn_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [4:0]    i_idx,
    input  logic          i_valid,
    input  fvn_pkg::t_acc i_acc,
    output logic          o_valid,
    output fvn_pkg::t_acc o_acc
);
    import fvn_pkg::*;

    localparam int NS = 10;

    // stage 1: scale coordinates, octave seed
    logic [NS-1:0] r_v;
    t_acc r_a1, r_a2, r_a3, r_a4, r_a5, r_a6, r_a7, r_a8, r_a9, r_a10;
    logic [31:0] r_xs, r_zs, r_s;
    logic        r_act1;
    logic [63:0] n_px, n_pz;
    logic [31:0] n_s;
    logic        n_act;

    always_comb begin
        n_act = ({1'b0, i_idx} < {1'b0, i_acc.cfg.octaves}) &&
                (i_idx < 5'(MAX_OCTAVES));
        n_px = {{32{i_acc.xc[31]}}, i_acc.xc} * {32'd0, i_acc.freq};
        n_pz = {{32{i_acc.zc[31]}}, i_acc.zc} * {32'd0, i_acc.freq};
        n_s  = i_acc.cfg.seed + ({27'd0, i_idx} *
               (i_acc.cfg.mode ? RIDGE_SEED_STEP : FBM_SEED_STEP));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[NS-2:0], i_valid};
        if (i_en) begin
            r_a1 <= i_acc; r_act1 <= n_act; r_s <= n_s;
            if (i_acc.cfg.mode) begin
                r_xs <= i_acc.xc << i_idx;
                r_zs <= i_acc.zc << i_idx;
            end else begin
                r_xs <= n_px[43:12];
                r_zs <= n_pz[43:12];
            end
        end
    end

    // stage 2: corner hash inputs, squared fractions
    logic [31:0] r_h2 [4];
    logic [15:0] r_fx, r_fz;
    logic [31:0] r_fx2, r_fz2;
    logic        r_act2;
    logic [31:0] n_xi, n_zi;
    always_comb begin
        n_xi = {{16{r_xs[31]}}, r_xs[31:16]};
        n_zi = {{16{r_zs[31]}}, r_zs[31:16]};
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a2 <= r_a1; r_act2 <= r_act1;
            r_h2[0] <= hash_in(r_s, n_xi, n_zi);
            r_h2[1] <= hash_in(r_s, n_xi + 32'd1, n_zi);
            r_h2[2] <= hash_in(r_s, n_xi, n_zi + 32'd1);
            r_h2[3] <= hash_in(r_s, n_xi + 32'd1, n_zi + 32'd1);
            r_fx <= r_xs[15:0]; r_fz <= r_zs[15:0];
            r_fx2 <= {16'd0, r_xs[15:0]} * {16'd0, r_xs[15:0]};
            r_fz2 <= {16'd0, r_zs[15:0]} * {16'd0, r_zs[15:0]};
        end
    end

    // stage 3: first mix half, fade cubes and quadratic factor
    logic [31:0] r_h3 [4];
    logic [31:0] r_t3x, r_t3z;
    logic [19:0] r_qx, r_qz;
    logic        r_act3;
    logic [47:0] n_cx, n_cz;
    function automatic logic [19:0] fade_q(input logic [15:0] f, input logic [31:0] f2);
        logic [39:0] p;
        begin
            p = (40'd10 << 32) + 40'd6 * {8'd0, f2} - (({24'd0, f} * 40'd15) << 16);
            return p[35:16];
        end
    endfunction
    always_comb begin
        n_cx = {16'd0, r_fx2} * {32'd0, r_fx};
        n_cz = {16'd0, r_fz2} * {32'd0, r_fz};
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a3 <= r_a2; r_act3 <= r_act2;
            for (int k = 0; k < 4; k++) r_h3[k] <= mix_step1(r_h2[k]);
            r_t3x <= n_cx[47:16]; r_t3z <= n_cz[47:16];
            r_qx <= fade_q(r_fx, r_fx2); r_qz <= fade_q(r_fz, r_fz2);
        end
    end

    // stage 4: finish first mix round, fade weights
    logic [31:0] r_h4 [4];
    logic [16:0] r_u4, r_w4;
    logic        r_act4;
    logic [51:0] n_ux, n_wz;
    always_comb begin
        n_ux = {20'd0, r_t3x} * {32'd0, r_qx};
        n_wz = {20'd0, r_t3z} * {32'd0, r_qz};
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a4 <= r_a3; r_act4 <= r_act3;
            for (int k = 0; k < 4; k++) r_h4[k] <= mix_step2(r_h3[k]);
            r_u4 <= n_ux[48:32]; r_w4 <= n_wz[48:32];
        end
    end

    // stage 5: second mix round, first half
    logic [31:0] r_h5 [4];
    logic [16:0] r_u5, r_w5;
    logic        r_act5;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a5 <= r_a4; r_act5 <= r_act4;
            for (int k = 0; k < 4; k++) r_h5[k] <= mix_step1(r_h4[k]);
            r_u5 <= r_u4; r_w5 <= r_w4;
        end
    end

    // stage 6: finish the hash, keep 24 bits per corner
    logic [23:0] r_c6 [4];
    logic [16:0] r_u6, r_w6;
    logic        r_act6;
    logic [31:0] n_m6 [4];
    always_comb begin
        for (int k = 0; k < 4; k++) n_m6[k] = mix_step2(r_h5[k]);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a6 <= r_a5; r_act6 <= r_act5;
            for (int k = 0; k < 4; k++) r_c6[k] <= n_m6[k][23:0];
            r_u6 <= r_u5; r_w6 <= r_w5;
        end
    end

    // stage 7: horizontal blends
    logic [23:0] r_top, r_bot;
    logic [16:0] r_w7;
    logic        r_act7;
    function automatic logic [23:0] lerp(input logic [23:0] a, input logic [23:0] b,
                                         input logic [16:0] t);
        logic [41:0] s;
        begin
            s = {18'd0, a} * (42'd65536 - {25'd0, t}) + {18'd0, b} * {25'd0, t};
            return s[39:16];
        end
    endfunction
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a7 <= r_a6; r_act7 <= r_act6; r_w7 <= r_w6;
            r_top <= lerp(r_c6[0], r_c6[1], r_u6);
            r_bot <= lerp(r_c6[2], r_c6[3], r_u6);
        end
    end

    // stage 8: vertical blend and ridge fold
    logic [23:0] r_n8, r_r8;
    logic        r_act8;
    logic [23:0] n_n;
    logic [24:0] n_tw, n_d;
    logic [23:0] n_r;
    always_comb begin
        n_n  = lerp(r_top, r_bot, r_w7);
        n_tw = {n_n, 1'b0};
        n_d  = (n_tw >= {1'b0, VAL_MAX}) ? n_tw - {1'b0, VAL_MAX} : {1'b0, VAL_MAX} - n_tw;
        n_r  = VAL_MAX - n_d[23:0];
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a8 <= r_a7; r_act8 <= r_act7; r_n8 <= n_n; r_r8 <= n_r;
        end
    end

    // stage 9: square the folded value
    logic [23:0] r_n9;
    logic [47:0] r_rr;
    logic        r_act9;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a9 <= r_a8; r_act9 <= r_act8; r_n9 <= r_n8;
            r_rr <= {24'd0, r_r8} * {24'd0, r_r8};
        end
    end

    // stage 10: accumulate and step frequency/amplitude
    logic [48:0] n_sqs;
    logic [23:0] n_sq;
    logic [63:0] n_term;
    logic [37:0] n_wt;
    logic [4:0]  n_k;
    logic [4:0]  n_sh;
    logic [48:0] n_ampg;
    logic [47:0] n_frq;
    t_acc        n_out;
    always_comb begin
        // exact floor division of a 48-bit product by 2^24-1
        n_sqs = {1'b0, r_rr} + {25'd0, r_rr[47:24]} + 49'd1;
        n_sq  = n_sqs[47:24];
        n_k   = (r_a9.cfg.octaves > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : r_a9.cfg.octaves;
        n_sh  = n_k - 5'd1 - i_idx;
        n_out = r_a9;
        n_ampg = {16'd0, r_a9.amp} * {33'd0, r_a9.cfg.gain};
        n_frq  = {16'd0, r_a9.freq} * {32'd0, r_a9.cfg.lacunarity};
        if (r_a9.cfg.mode) begin
            n_wt   = 38'd1 << n_sh;
            n_term = {40'd0, n_sq} << n_sh;
        end else begin
            n_wt   = {5'd0, r_a9.amp};
            n_term = {31'd0, r_a9.amp} * {40'd0, r_n9};
        end
        if (r_act9) begin
            n_out.sum  = r_a9.sum + n_term;
            n_out.norm = r_a9.norm + n_wt;
            n_out.freq = n_frq[43:12];
            n_out.amp  = (|n_ampg[48:47]) ? 33'h0ffffffff : {1'b0, n_ampg[46:15]};
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) r_a10 <= n_out;
    end

    assign o_valid = r_v[NS-1];
    assign o_acc   = r_a10;
endmodule

// ===== design/fvn_div.sv =====
// Final normalization: pipelined restoring divider, one quotient bit per stage.
// Depends on fvn_pkg; instantiated once by fractal_value_noise_2d.
module fvn_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_num,
    input  logic [37:0] i_den,
    output logic        o_valid,
    output logic [23:0] o_quo
);
    import fvn_pkg::*;

    localparam int QB = 24;
    // quotient fits in 24 bits: sum <= VAL_MAX * norm
    logic [QB:0]  r_v;
    logic [63:0]  r_rem [QB+1];
    logic [37:0]  r_den [QB+1];
    logic [QB-1:0] r_q  [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[QB-1:0], i_valid};
        if (i_en) begin
            r_rem[0] <= i_num; r_den[0] <= i_den; r_q[0] <= '0;
        end
    end

    for (genvar g = 0; g < QB; g++) begin : g_step
        logic [63:0] n_sub;
        logic        n_ok;
        always_comb begin
            n_sub = {26'd0, r_den[g]} << (QB - 1 - g);
            n_ok  = (r_den[g] != 38'd0) && (r_rem[g] >= n_sub) &&
                    ((({26'd0, r_den[g]} << (QB - 1 - g)) >> (QB - 1 - g)) ==
                     {26'd0, r_den[g]});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g+1] <= r_den[g];
                r_rem[g+1] <= n_ok ? r_rem[g] - n_sub : r_rem[g];
                r_q[g+1]   <= r_q[g] | (n_ok ? (QB'(1) << (QB - 1 - g)) : '0);
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_quo   = r_q[QB];
endmodule

// ===== design/fractal_value_noise_2d.sv =====
// Top level of the 2D fractal value noise block: config registers, cell chain, divider.
// Depends on fvn_pkg, fvn_cell and fvn_div.
//
// Usage: a coordinate request (x in tdata[31:0], z in tdata[63:32], signed Q16.16)
// enters on the s_axis channel; one 24-bit noise sample leaves on m_axis.
// The pipeline is a chain of MAX_OCTAVES octave cells, ten stages each, followed
// by a 25-stage divider and the output register. Throughput is one request per
// cycle unless the receiver stalls. The config snapshot travels with each request.
// When the receiver stalls, the output register holds its result and the whole
// chain freezes; s_axis_tready drops only while the output register is full and
// not being taken. Reset clears all valid flags and loads the register defaults
// (seed 0, 4 octaves, lacunarity 2.0, gain 0.5, fbm mode). Config writes are taken
// on any cycle with i_cfg_we high outside reset.
module fractal_value_noise_2d (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // x_coord[31:0], z_coord[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // noise_value[23:0]
);
    import fvn_pkg::*;

    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{seed: 32'd0, octaves: 5'd4, lacunarity: 16'd8192,
                       gain: 16'd16384, mode: 1'b0};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SEED: r_cfg.seed       <= i_cfg_data;
                REG_OCT:  r_cfg.octaves    <= i_cfg_data[4:0];
                REG_LAC:  r_cfg.lacunarity <= i_cfg_data[15:0];
                REG_GAIN: r_cfg.gain       <= i_cfg_data[15:0];
                REG_MODE: r_cfg.mode       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_ov;
    logic [23:0] r_od;
    assign w_en = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    logic [MAX_OCTAVES:0] w_v;
    t_acc w_a [MAX_OCTAVES+1];
    assign w_v[0] = s_axis_tvalid && w_en;
    always_comb begin
        w_a[0] = '0;
        w_a[0].xc = s_axis_tdata[31:0];
        w_a[0].zc = s_axis_tdata[63:32];
        w_a[0].freq = 32'd4096;
        w_a[0].amp = 33'd32768;
        w_a[0].cfg = r_cfg;
    end

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
        fvn_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_idx(OCT_W'(g)),
            .i_valid(w_v[g]), .i_acc(w_a[g]), .o_valid(w_v[g+1]), .o_acc(w_a[g+1])
        );
    end

    logic w_dv;
    logic [23:0] w_dq;
    fvn_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_v[MAX_OCTAVES]),
        .i_num(w_a[MAX_OCTAVES].sum), .i_den(w_a[MAX_OCTAVES].norm),
        .o_valid(w_dv), .o_quo(w_dq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= w_dv;
        if (w_en) r_od <= w_dq;
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov && $stable(r_od)) else $error("result lost");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov |-> s_axis_tready) else $error("stalled while empty");
endmodule
